[sv/mpfa_pkg.sv]
// ============================================================================
// mpfa_pkg
// Shared constants for the p = 2^255 - 19 Montgomery field ALU: the prime,
// the radix-derived constants, command codes and exponent chain tails.
// ============================================================================
`default_nettype none

package mpfa_pkg;

  localparam int LimbW = 64;
  localparam int ElemW = 256;
  // signed working width of the bit-serial Montgomery accumulator
  localparam int AccW  = ElemW + 3;

  localparam logic [ElemW-1:0] PRIME =
    256'h7FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFED;
  localparam logic [ElemW-1:0] R_MOD_P  = 256'd38;
  localparam logic [ElemW-1:0] R2_MOD_P = 256'd1444;
  localparam logic [ElemW-1:0] ONE      = 256'd1;

  // command codes
  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_NEG    = 4'd2;
  localparam logic [3:0] CMD_MUL    = 4'd3;
  localparam logic [3:0] CMD_TO     = 4'd4;
  localparam logic [3:0] CMD_FROM   = 4'd5;
  localparam logic [3:0] CMD_INV    = 4'd6;
  localparam logic [3:0] CMD_LEG    = 4'd7;
  localparam logic [3:0] CMD_REDUCE = 4'd8;

  // exponent tails after a^(2^248-1), msb first
  localparam logic [6:0] INV_TAIL     = 7'h6B;
  localparam logic [2:0] INV_TAIL_TOP = 3'd6;
  localparam logic [6:0] LEG_TAIL     = 7'h36;
  localparam logic [2:0] LEG_TAIL_TOP = 3'd5;

endpackage

`default_nettype wire

[sv/montgomery_prime_field_alu.sv]
// ============================================================================
// montgomery_prime_field_alu
// Field ALU mod 2^255-19 with R = 2^256: add, sub, neg, reduce, Montgomery
// multiply with bit-serial interleaved reduction, and exponent chains.
// ============================================================================
// Steps: unused codes go straight to the result; neg/reduce subtract p if that
//   does not borrow; add/sub first fold the carry or borrow with 38. Mul and
//   to/from Montgomery run one operand bit per cycle in a 259-bit accumulator.
// Inverse takes 270 and Legendre 268 chained multiplies. One item is in flight
//   at a time; the next is taken while a result waits.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, output empty.
`default_nettype none

module montgomery_prime_field_alu
  import mpfa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3
  input  wire logic [511:0] s_axis_tdata,
  // command
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // c_w0, c_w1, c_w2, c_w3, legendre_bit, zero fill
  output logic [263:0]      m_axis_tdata
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_FIX38 = 4'd2;
  localparam logic [3:0] ST_RED   = 4'd3;
  localparam logic [3:0] ST_LOAD  = 4'd4;
  localparam logic [3:0] ST_RUN   = 4'd5;
  localparam logic [3:0] ST_FIX   = 4'd6;
  localparam logic [3:0] ST_NEXT  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [1:0] PH_POW   = 2'd0;
  localparam logic [1:0] PH_SHIFT = 2'd1;
  localparam logic [1:0] PH_TAIL  = 2'd2;

  logic [3:0]       state_q;
  logic [3:0]       cmd_q;
  logic [ElemW-1:0] a_q, b_q, acc_q, prev_q, y_q, x_q;
  logic [ElemW-1:0] keep_q [4];
  logic             flag_q;
  logic [AccW-1:0]  u_q, bmp_q;
  logic [7:0]       bc_q;
  logic [1:0]       ph_q;
  logic [2:0]       idx_q;
  logic [6:0]       cnt_q;
  logic             mdone_q;
  logic [ElemW-1:0] out_c_q;
  logic             out_bit_q;
  logic             out_valid_q;

  // arithmetic helpers
  logic [ElemW:0]   add_ab, sub_ab, red_d;
  logic [ElemW-1:0] neg_a, fix38;
  logic [AccW-1:0]  term, u_sum, u_fix;
  logic             odd;
  logic [6:0]       need_pow, need_sh;
  logic             tail_bit, chain, out_free;
  logic [1:0]       kidx;

  assign add_ab = {1'b0, a_q} + {1'b0, b_q};
  assign sub_ab = {1'b0, a_q} - {1'b0, b_q};
  assign neg_a  = PRIME - a_q;
  assign fix38  = (cmd_q == CMD_ADD) ? acc_q + R_MOD_P : acc_q - R_MOD_P;
  assign red_d  = {1'b0, acc_q} - {1'b0, PRIME};

  // one operand bit per cycle: add x_i*y and clear the low bit with p
  assign odd = u_q[0] ^ (x_q[0] & y_q[0]);
  always_comb begin
    case ({x_q[0], odd})
      2'b10:   term = {3'b000, y_q};
      2'b01:   term = -{3'b000, PRIME};
      2'b11:   term = bmp_q;
      default: term = '0;
    endcase
  end
  assign u_sum = u_q + term;
  assign u_fix = u_q[AccW-1] ? u_q + {3'b000, PRIME} : u_q;

  assign need_pow = 7'd1 << idx_q;
  assign need_sh  = 7'd64 >> idx_q[1:0];
  assign tail_bit = (cmd_q == CMD_INV) ? INV_TAIL[idx_q] : LEG_TAIL[idx_q];
  assign chain    = (cmd_q == CMD_INV) || (cmd_q == CMD_LEG);
  assign kidx     = 2'(3'd5 - idx_q);
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_bit_q, out_c_q};

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ph_q        <= PH_POW;
      idx_q       <= '0;
      cnt_q       <= '0;
      mdone_q     <= 1'b0;
      bc_q        <= '0;
      cmd_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      acc_q       <= '0;
      prev_q      <= '0;
      y_q         <= '0;
      x_q         <= '0;
      keep_q      <= '{default: '0};
      flag_q      <= 1'b0;
      u_q         <= '0;
      bmp_q       <= '0;
      out_c_q     <= '0;
      out_bit_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != ST_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            a_q     <= s_axis_tdata[255:0];
            b_q     <= s_axis_tdata[511:256];
            cmd_q   <= s_axis_tuser;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          prev_q  <= a_q;
          ph_q    <= PH_POW;
          idx_q   <= '0;
          cnt_q   <= '0;
          mdone_q <= 1'b0;
          case (cmd_q) inside
            CMD_ADD: begin
              {flag_q, acc_q} <= add_ab;
              state_q <= ST_FIX38;
            end
            CMD_SUB: begin
              {flag_q, acc_q} <= sub_ab;
              state_q <= ST_FIX38;
            end
            CMD_NEG: begin
              acc_q   <= neg_a;
              state_q <= ST_RED;
            end
            CMD_REDUCE: begin
              acc_q   <= a_q;
              state_q <= ST_RED;
            end
            CMD_MUL: begin
              acc_q   <= a_q;
              y_q     <= b_q;
              state_q <= ST_LOAD;
            end
            CMD_TO: begin
              acc_q   <= a_q;
              y_q     <= R2_MOD_P;
              state_q <= ST_LOAD;
            end
            CMD_FROM: begin
              acc_q   <= a_q;
              y_q     <= ONE;
              state_q <= ST_LOAD;
            end
            CMD_INV, CMD_LEG: begin
              acc_q   <= a_q;
              state_q <= ST_NEXT;
            end
            default: begin
              acc_q   <= '0;
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_FIX38: begin
          if (flag_q) acc_q <= fix38;
          state_q <= ST_RED;
        end
        ST_RED: begin
          if (!red_d[ElemW]) acc_q <= red_d[ElemW-1:0];
          state_q <= ST_DONE;
        end
        ST_LOAD: begin
          x_q     <= acc_q;
          u_q     <= '0;
          bmp_q   <= {3'b000, y_q} - {3'b000, PRIME};
          bc_q    <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          u_q  <= {u_sum[AccW-1], u_sum[AccW-1:1]};
          x_q  <= x_q >> 1;
          bc_q <= bc_q + 8'd1;
          if (bc_q == 8'hFF) state_q <= ST_FIX;
        end
        ST_FIX: begin
          acc_q   <= u_fix[ElemW-1:0];
          state_q <= chain ? ST_NEXT : ST_DONE;
        end
        ST_NEXT: begin
          unique case (ph_q)
            PH_POW: begin
              if (mdone_q) begin
                if (idx_q >= 3'd2 && idx_q <= 3'd5) keep_q[kidx] <= acc_q;
                prev_q  <= acc_q;
                cnt_q   <= '0;
                mdone_q <= 1'b0;
                if (idx_q == 3'd6) begin
                  ph_q  <= PH_SHIFT;
                  idx_q <= '0;
                end else begin
                  idx_q <= idx_q + 3'd1;
                end
              end else if (cnt_q != need_pow) begin
                y_q     <= acc_q;
                cnt_q   <= cnt_q + 7'd1;
                state_q <= ST_LOAD;
              end else begin
                y_q     <= prev_q;
                mdone_q <= 1'b1;
                state_q <= ST_LOAD;
              end
            end
            PH_SHIFT: begin
              if (mdone_q) begin
                cnt_q   <= '0;
                mdone_q <= 1'b0;
                if (idx_q == 3'd3) begin
                  ph_q  <= PH_TAIL;
                  idx_q <= (cmd_q == CMD_INV) ? INV_TAIL_TOP : LEG_TAIL_TOP;
                end else begin
                  idx_q <= idx_q + 3'd1;
                end
              end else if (cnt_q != need_sh) begin
                y_q     <= acc_q;
                cnt_q   <= cnt_q + 7'd1;
                state_q <= ST_LOAD;
              end else begin
                y_q     <= keep_q[idx_q[1:0]];
                mdone_q <= 1'b1;
                state_q <= ST_LOAD;
              end
            end
            PH_TAIL: begin
              if (cnt_q == '0) begin
                y_q     <= acc_q;
                cnt_q   <= 7'd1;
                state_q <= ST_LOAD;
              end else if (tail_bit && !mdone_q) begin
                y_q     <= a_q;
                mdone_q <= 1'b1;
                state_q <= ST_LOAD;
              end else if (idx_q == '0) begin
                state_q <= ST_DONE;
              end else begin
                idx_q   <= idx_q - 3'd1;
                cnt_q   <= '0;
                mdone_q <= 1'b0;
              end
            end
            default: state_q <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            out_c_q     <= acc_q;
            out_bit_q   <= (cmd_q == CMD_LEG) & acc_q[0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_load_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> bc_q == '0)
    else $error("bit counter not cleared on multiply load");

  a_fix_without_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX && !chain) |=> state_q == ST_DONE)
    else $error("single multiply did not finish after correction");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result presented outside the completion state");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ============================================================================
// montgomery_prime_field_alu testbench
// Drives field commands over the input stream and checks every result
// against a behavioural model of the p = 2^255-19 arithmetic, with random
// idling on both sides and one long output hold-off.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
  import mpfa_pkg::*;

  localparam int WatchdogLimit = 250000;
  localparam logic [3:0] CMD_SPARE_LO = 4'd9;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [255:0] c;
    logic         leg;
  } field_result_t;

  // field arithmetic model and store of pending results
  class field_scoreboard;
    field_result_t pending_q[$];
    logic [255:0]  p_inv;
    int            errors;
    int            checked;

    function new();
      logic [255:0] x, e;
      x = PRIME;
      // newton iteration for p^-1 mod 2^256
      repeat (8) begin
        e = 256'd2 - x * PRIME;
        x = x * e;
      end
      p_inv = x;
      errors = 0;
      checked = 0;
    endfunction

    function logic [255:0] redc(logic [511:0] t);
      logic [255:0] m;
      logic [511:0] mp, d;
      logic [255:0] c;
      m  = t[255:0] * p_inv;
      mp = {256'b0, m} * {256'b0, PRIME};
      d  = t - mp;
      c  = d[511:256];
      if (t < mp) c = c + PRIME;
      return c;
    endfunction

    function logic [255:0] mont_mul(logic [255:0] x, logic [255:0] y);
      return redc({256'b0, x} * {256'b0, y});
    endfunction

    function logic [255:0] cond_reduce(logic [255:0] x);
      return (x >= PRIME) ? x - PRIME : x;
    endfunction

    // a^(2^248-1) followed by the tail bits, msb first
    function logic [255:0] power_chain(logic [255:0] a, logic [6:0] tail, int tail_len);
      logic [255:0] acc, prev;
      logic [255:0] keep [4];
      int shifts [4];
      shifts = '{64, 32, 16, 8};
      acc = a;
      prev = a;
      for (int j = 0; j < 7; j++) begin
        for (int i = 0; i < (1 << j); i++) acc = mont_mul(acc, acc);
        acc = mont_mul(acc, prev);
        if (j >= 2 && j <= 5) keep[5 - j] = acc;
        prev = acc;
      end
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < shifts[k]; i++) acc = mont_mul(acc, acc);
        acc = mont_mul(acc, keep[k]);
      end
      for (int k = tail_len - 1; k >= 0; k--) begin
        acc = mont_mul(acc, acc);
        if (tail[k]) acc = mont_mul(acc, a);
      end
      return acc;
    endfunction

    function void note_command(logic [3:0] cmd, logic [255:0] a, logic [255:0] b);
      field_result_t r;
      logic [256:0] s;
      r.c = '0;
      r.leg = 1'b0;
      case (cmd)
        CMD_ADD: begin
          s = {1'b0, a} + {1'b0, b};
          r.c = s[256] ? s[255:0] + R_MOD_P : s[255:0];
          r.c = cond_reduce(r.c);
        end
        CMD_SUB: begin
          r.c = a - b;
          if (a < b) r.c = r.c - R_MOD_P;
          r.c = cond_reduce(r.c);
        end
        CMD_NEG:    r.c = cond_reduce(PRIME - a);
        CMD_MUL:    r.c = mont_mul(a, b);
        CMD_TO:     r.c = mont_mul(a, R2_MOD_P);
        CMD_FROM:   r.c = redc({256'b0, a});
        CMD_INV:    r.c = power_chain(a, INV_TAIL, 7);
        CMD_LEG: begin
          r.c = power_chain(a, LEG_TAIL, 6);
          r.leg = r.c[0];
        end
        CMD_REDUCE: r.c = cond_reduce(a);
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [255:0] got, logic [255:0] want);
      errors++;
      $display("mismatch %0d: %s got %h want %h", errors, what, got, want);
    endtask

    task check_result(logic [263:0] data);
      field_result_t w;
      checked++;
      if (pending_q.size() == 0) begin
        report("unexpected transfer", data[255:0], '0);
      end else begin
        w = pending_q.pop_front();
        if (data[255:0] !== w.c) report("c", data[255:0], w.c);
        if (data[256] !== w.leg) report("legendre_bit", {255'b0, data[256]}, {255'b0, w.leg});
      end
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [511:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [263:0] m_axis_tdata;

  field_scoreboard sb = new();
  bit  steady_flow = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;
  int  long_ops = 0;
  int  cmd_count [16];

  montgomery_prime_field_alu uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // receiver: random stalls, one long hold-off once results flow
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sb.checked == 30) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 23);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results pending", sb.pending_q.size());
      $display("montgomery_prime_field_alu regression: fail");
      $finish;
    end
  end

  task send_command(logic [3:0] cmd, logic [255:0] a, logic [255:0] b);
    if (!steady_flow && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, a, b);
    cmd_count[cmd]++;
  endtask

  function automatic logic [255:0] rand_elem();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    case ($urandom_range(5))
      0: v = PRIME - v[3:0];
      1: v = PRIME + v[4:0];
      2: v = {224'b0, v[31:0]};
      3: v = '1 - v[2:0];
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [3:0] cmd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed extremes and special cases
    send_command(CMD_ADD, PRIME - 1, 256'd1);
    send_command(CMD_ADD, '1, '1);
    send_command(CMD_ADD, '0, '0);
    send_command(CMD_SUB, '0, 256'd1);
    send_command(CMD_SUB, '0, '1);
    send_command(CMD_SUB, '1, '1);
    send_command(CMD_NEG, '0, '0);
    send_command(CMD_NEG, '1, '0);
    send_command(CMD_NEG, PRIME, '0);
    send_command(CMD_MUL, '1, '1);
    send_command(CMD_MUL, '0, rand_elem());
    send_command(CMD_MUL, PRIME - 1, PRIME - 1);
    send_command(CMD_TO, '1, '0);
    send_command(CMD_TO, 256'd1, '0);
    send_command(CMD_FROM, '1, '0);
    send_command(CMD_FROM, R_MOD_P, '0);
    send_command(CMD_REDUCE, PRIME, '0);
    send_command(CMD_REDUCE, PRIME - 1, '0);
    send_command(CMD_REDUCE, '1, '0);
    send_command(CMD_SPARE_LO, '1, '1);
    send_command(CMD_SPARE_HI, '1, '1);
    send_command(CMD_INV, R2_MOD_P, '0);
    send_command(CMD_LEG, PRIME - R_MOD_P, '0);

    // random part; the chain commands are slow, so only a few of them
    for (int n = 0; n < 77; n++) begin
      steady_flow = (n >= 35 && n < 60);
      cmd = 4'($urandom_range(15));
      if (cmd > CMD_REDUCE && $urandom_range(3) != 0) cmd = 4'($urandom_range(5));
      if (cmd == CMD_INV || cmd == CMD_LEG) begin
        if (long_ops >= 4) cmd = CMD_MUL;
        else long_ops++;
      end
      send_command(cmd, rand_elem(), rand_elem());
    end
    s_axis_tvalid <= 1'b0;
    steady_flow = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("results checked: %0d, long hold-off applied: %0d", sb.checked, hold_done);
    $display("commands add %0d sub %0d neg %0d mul %0d to %0d from %0d inv %0d leg %0d red %0d",
      cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
      cmd_count[5], cmd_count[6], cmd_count[7], cmd_count[8]);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("montgomery_prime_field_alu regression: pass");
    else
      $display("montgomery_prime_field_alu regression: fail");
    $finish;
  end

endmodule

[filelist.f]
sv/mpfa_pkg.sv
sv/montgomery_prime_field_alu.sv
tb/testbench.sv
